[rtl/mcost_pkg.sv]
package mcost_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam int ID_W = 8;
  localparam int DELAY_W = 14;
  localparam int TICKS_W = 16;
  localparam int TICKS_PER_MS_SHIFT = 2;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_REMOVE,
    REQ_QUERY,
    REQ_TICK
  } req_t;

  localparam logic RES_ANSWER = 1'b0;
  localparam logic RES_EXPIRY = 1'b1;

  typedef struct packed {
    req_t               kind;
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
  } cmd_t;

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] index;
  } pick_t;

  function automatic pick_t lowest_set(input logic [CHANNELS-1:0] bits);
    pick_t p;
    p.found = 1'b0;
    p.index = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        p.found = 1'b1;
        p.index = CH_W'(i);
      end
    end
    return p;
  endfunction

endpackage

[rtl/multi_channel_one_shot_timer.sv]
// Multi-channel one-shot timer with eight pending delays, each tagged by an ID.
// Input beats carry a request kind on s_tuser (add, remove, query, tick) and
// the ID and delay in milliseconds on s_tdata. Output beats carry the result
// kind on m_tuser, the ok flag and expired ID on m_tdata, and m_tlast on the
// final beat caused by one input beat.
// An add, remove or query gives one registered answer beat.
// A tick counts every pending delay down by one quarter millisecond and gives
// one expiry beat per delay that runs out, in slot order, one beat per cycle
// unless the receiver stalls; a tick with no expiry gives no beat.
// A two-entry queue sits between the input stage and the table engine, so new
// requests are taken while a result waits. The engine handles one request per
// cycle while the output is free; a tick with expiries holds it until its last beat.
// When the receiver stalls, the output register holds its beat, the engine
// waits, and the queue fills before s_tready drops.
// Reset empties the queue, frees every slot and drops m_tvalid.
module multi_channel_one_shot_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // entry_id[7:0], delay[21:8], zero fill
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ok[0], expired_id[8:1], zero fill
  output logic        m_tuser,   // result_kind[0]
  output logic        m_tlast
);

  logic            cmd_valid;
  logic            cmd_ready;
  mcost_pkg::cmd_t cmd;

  mcost_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mcost_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[rtl/mcost_front.sv]
module mcost_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output mcost_pkg::cmd_t      cmd
);

  mcost_pkg::cmd_t                       queue [mcost_pkg::FIFO_DEPTH];
  logic [mcost_pkg::FIFO_AW-1:0]         wr_ptr;
  logic [mcost_pkg::FIFO_AW-1:0]         rd_ptr;
  logic [mcost_pkg::FIFO_CW-1:0]         count;
  mcost_pkg::cmd_t                       incoming;
  logic [mcost_pkg::DELAY_W-1:0]         req_ms;
  logic                                  push;
  logic                                  pop;

  assign req_ms = s_tdata[mcost_pkg::ID_W +: mcost_pkg::DELAY_W];

  always_comb begin
    incoming.kind = mcost_pkg::req_t'(s_tuser);
    incoming.id   = s_tdata[mcost_pkg::ID_W-1:0];
    if (req_ms == '0) begin
      incoming.ticks = mcost_pkg::TICKS_W'(1);
    end else begin
      incoming.ticks = {req_ms, {mcost_pkg::TICKS_PER_MS_SHIFT{1'b0}}};
    end
  end

  assign s_tready  = (count != mcost_pkg::FIFO_CW'(mcost_pkg::FIFO_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mcost_pkg::FIFO_AW'(mcost_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mcost_pkg::FIFO_AW'(mcost_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/mcost_back.sv]
module mcost_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  mcost_pkg::cmd_t      cmd,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                                state;
  logic [mcost_pkg::CHANNELS-1:0]        slot_valid;
  logic [mcost_pkg::ID_W-1:0]            slot_id    [mcost_pkg::CHANNELS];
  logic [mcost_pkg::TICKS_W-1:0]         slot_ticks [mcost_pkg::CHANNELS];
  logic [mcost_pkg::CHANNELS-1:0]        expire_mask;
  logic                                  out_kind;
  logic                                  out_ok;
  logic [mcost_pkg::ID_W-1:0]            out_id;
  logic                                  out_last;

  logic                                  out_free;
  logic                                  out_load;
  logic [mcost_pkg::CHANNELS-1:0]        hit_mask;
  logic [mcost_pkg::CHANNELS-1:0]        due_mask;
  mcost_pkg::pick_t                      hit_pick;
  mcost_pkg::pick_t                      free_pick;
  mcost_pkg::pick_t                      emit_pick;
  logic [mcost_pkg::CHANNELS-1:0]        expire_mask_next;

  always_comb begin
    for (int i = 0; i < mcost_pkg::CHANNELS; i++) begin
      hit_mask[i] = slot_valid[i] && (slot_id[i] == cmd.id);
      due_mask[i] = slot_valid[i] && (slot_ticks[i] <= mcost_pkg::TICKS_W'(1));
    end
    hit_pick  = mcost_pkg::lowest_set(hit_mask);
    free_pick = mcost_pkg::lowest_set(~slot_valid);
    emit_pick = mcost_pkg::lowest_set(expire_mask);
    expire_mask_next = expire_mask;
    expire_mask_next[emit_pick.index] = 1'b0;
  end

  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free &&
                     (((state == ST_IDLE) && cmd_valid && (cmd.kind != mcost_pkg::REQ_TICK)) ||
                      (state == ST_EMIT));
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign m_tdata   = {{(16 - mcost_pkg::ID_W - 1){1'b0}}, out_id, out_ok};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot_valid  <= '0;
      expire_mask <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && out_free) begin
            out_kind <= mcost_pkg::RES_ANSWER;
            out_id   <= '0;
            out_last <= 1'b1;
            case (cmd.kind)
              mcost_pkg::REQ_ADD: begin
                out_ok   <= free_pick.found && !hit_pick.found;
                if (free_pick.found && !hit_pick.found) begin
                  slot_valid[free_pick.index] <= 1'b1;
                  slot_id[free_pick.index]    <= cmd.id;
                  slot_ticks[free_pick.index] <= cmd.ticks;
                end
              end
              mcost_pkg::REQ_REMOVE: begin
                out_ok   <= hit_pick.found;
                if (hit_pick.found) begin
                  slot_valid[hit_pick.index] <= 1'b0;
                end
              end
              mcost_pkg::REQ_QUERY: begin
                out_ok   <= hit_pick.found;
              end
              default: begin
                for (int i = 0; i < mcost_pkg::CHANNELS; i++) begin
                  if (due_mask[i]) begin
                    slot_valid[i] <= 1'b0;
                  end else if (slot_valid[i]) begin
                    slot_ticks[i] <= slot_ticks[i] - 1'b1;
                  end
                end
                expire_mask <= due_mask;
                if (due_mask != '0) begin
                  state <= ST_EMIT;
                end
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_kind    <= mcost_pkg::RES_EXPIRY;
            out_ok      <= 1'b0;
            out_id      <= slot_id[emit_pick.index];
            out_last    <= (expire_mask_next == '0);
            expire_mask <= expire_mask_next;
            if (expire_mask_next == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/mcost_checker.sv]
module mcost_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mcost_pkg::RES_ANSWER) |-> m_tlast)
    else $error("answer beat without last");

  a_answer_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mcost_pkg::RES_ANSWER) |-> (m_tdata[8:1] == '0))
    else $error("answer beat carries an ID");

  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mcost_pkg::RES_EXPIRY) |-> !m_tdata[0])
    else $error("expiry beat with ok set");

endmodule

bind multi_channel_one_shot_timer mcost_checker u_mcost_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
